/* rtl/core/call_graph_profile_accumulator_top_macros.svh */
// Assertion macros for the call graph profile accumulator
`ifndef CALL_GRAPH_PROFILE_ACCUMULATOR_TOP_MACROS_SVH
`define CALL_GRAPH_PROFILE_ACCUMULATOR_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CGPA_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication
`define CGPA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

/* rtl/core/cgpa_pkg.sv */
// ----------------------------------------------------------------------------
// cgpa_pkg
// Shared types and codes of the call graph profile accumulator.
// ----------------------------------------------------------------------------
package cgpa_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_RET  = 1'b1;

  // Request as it travels from the front end to the back end
  typedef struct packed {
    logic        kind;
    logic [7:0]  func;
    logic [63:0] ts;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fn_index;
    logic [31:0] call_count;
    logic [31:0] nonrec_count;
    logic [63:0] total_time;
    logic [63:0] sub_time;
    logic [31:0] edge_calls;
    logic [31:0] edge_nonrec;
    logic [63:0] edge_time;
    logic [7:0]  stack_depth;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_RDSTK, S_SRCH, S_SRCHW, S_RDFN, S_RDFNW, S_CALC, S_WR, S_OUT
  } state_t;

  function automatic logic [31:0] inc32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction
  function automatic logic [7:0] inc8(input logic [7:0] v);
    return (v == '1) ? v : v + 8'd1;
  endfunction
  function automatic logic [7:0] dec8(input logic [7:0] v);
    return (v == '0) ? v : v - 8'd1;
  endfunction
  function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction
endpackage

/* rtl/core/cgpa_front.sv */
// ----------------------------------------------------------------------------
// cgpa_front
// Input side: takes events and queues them as requests for the back end.
// ----------------------------------------------------------------------------
module cgpa_front
  import cgpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_req
);
  localparam int QD = 2;
  req_t       mem [QD];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_req    = mem[rp];

  // Hold incoming requests in a two-entry queue
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end
endmodule

/* rtl/core/cgpa_back.sv */
// ----------------------------------------------------------------------------
// cgpa_back
// Execution side: stack, function table, edge table and the result register.
// ----------------------------------------------------------------------------
module cgpa_back
  import cgpa_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int NUM_FUNCS   = 256,
  parameter int NUM_EDGES   = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  req_t q_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(NUM_FUNCS);
  localparam int EW = $clog2(NUM_EDGES);
  localparam int KW = 2 * FW;

  // Stack memories
  logic [FW-1:0] stk_f [STACK_DEPTH];
  logic [63:0]   stk_t [STACK_DEPTH];
  // Function table, one entry per function
  logic [31:0] fc_m [NUM_FUNCS];
  logic [31:0] fn_m [NUM_FUNCS];
  logic [7:0]  fl_m [NUM_FUNCS];
  logic [63:0] ft_m [NUM_FUNCS];
  logic [63:0] fs_m [NUM_FUNCS];
  logic [NUM_FUNCS-1:0] fvalid;
  // Edge table, filled in order
  logic [KW-1:0] ek_m [NUM_EDGES];
  logic [31:0]   ec_m [NUM_EDGES];
  logic [31:0]   en_m [NUM_EDGES];
  logic [7:0]    el_m [NUM_EDGES];
  logic [63:0]   et_m [NUM_EDGES];

  state_t state, state_next;
  req_t   rq;
  logic [SW:0]   sp;
  logic [EW:0]   used;
  logic [EW:0]   si;
  logic [FW-1:0] f, p;
  logic [63:0]   t0;
  logic          has_p, efound, is_empty;
  logic [EW-1:0] e;
  logic [KW-1:0] kq;
  // Registered reads
  logic [FW-1:0] rd_sf;
  logic [63:0]   rd_st;
  logic [KW-1:0] rd_k;
  logic [31:0]   c_calls, c_nonrec, r_ec, r_en;
  logic [7:0]    c_lvl, r_el;
  logic [63:0]   c_tot, c_sub, p_sub, r_et;
  logic          c_v, p_v;
  logic [31:0]   w_calls, w_nonrec, w_ec, w_en;
  logic [7:0]    w_lvl, w_el;
  logic [63:0]   w_tot, w_psub, w_et;
  logic [1:0]    w_status;
  logic          do_fn, do_psub, do_edge, do_push, new_edge;
  logic [63:0]   elapsed;
  logic [SW-1:0] rd_addr;
  logic [FW-1:0] req_func;

  assign q_ready  = (state == S_IDLE) && !out_valid;
  assign req_func = q_req.func[FW-1:0];
  assign kq       = {p, f};

  // Read stack at a chosen slot
  always_comb begin
    rd_addr = sp[SW-1:0] - SW'(1);
    if (state == S_POP) rd_addr = sp[SW-1:0] - SW'(2);
  end
  always_ff @(posedge clk) begin
    rd_sf <= stk_f[rd_addr];
    rd_st <= stk_t[rd_addr];
    rd_k  <= ek_m[si[EW-1:0]];
    r_ec  <= ec_m[e]; r_en <= en_m[e]; r_el <= el_m[e]; r_et <= et_m[e];
    c_calls <= fc_m[f]; c_nonrec <= fn_m[f]; c_lvl <= fl_m[f];
    c_tot <= ft_m[f]; c_sub <= fs_m[f]; c_v <= fvalid[f];
    p_sub <= fs_m[p]; p_v <= fvalid[p];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_valid && q_ready) state_next = S_POP;
      S_POP:   state_next = S_RDSTK;
      S_RDSTK: state_next = S_SRCH;
      S_SRCH:  state_next = (has_p && !efound && si < used) ? S_SRCHW : S_RDFN;
      S_SRCHW: state_next = S_SRCH;
      S_RDFN:  state_next = S_RDFNW;
      S_RDFNW: state_next = S_CALC;
      S_CALC:  state_next = S_WR;
      S_WR:    state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Work out new statistics from the registered reads
  always_comb begin
    logic [31:0] cc, cn, ec, en;
    logic [7:0]  cl, el;
    logic [63:0] ct, ps, et;
    cc = c_v ? c_calls : '0; cn = c_v ? c_nonrec : '0; cl = c_v ? c_lvl : '0;
    ct = c_v ? c_tot : '0; ps = p_v ? p_sub : '0;
    ec = efound ? r_ec : '0; en = efound ? r_en : '0;
    el = efound ? r_el : '0; et = efound ? r_et : '0;
    elapsed = (rq.ts >= t0) ? rq.ts - t0 : '0;
    w_calls = cc; w_nonrec = cn; w_lvl = cl; w_tot = ct; w_psub = ps;
    w_ec = ec; w_en = en; w_el = el; w_et = et;
    w_status = ST_OK; do_fn = 1'b0; do_psub = 1'b0; do_edge = 1'b0;
    do_push = 1'b0; new_edge = 1'b0;
    if (rq.kind == KIND_CALL) begin
      if (sp >= (SW+1)'(STACK_DEPTH)) w_status = ST_DROPPED;
      else if (has_p && !efound && used >= (EW+1)'(NUM_EDGES)) w_status = ST_DROPPED;
      else begin
        do_push = 1'b1; do_fn = 1'b1;
        w_calls = inc32(cc); w_lvl = inc8(cl);
        if (has_p) begin
          do_edge = 1'b1; new_edge = !efound;
          w_ec = inc32(ec); w_el = inc8(el);
        end
      end
    end else if (is_empty) begin
      w_status = ST_EMPTY;
    end else if (!has_p) begin
      do_fn = 1'b1;
      w_tot = add64(ct, elapsed); w_nonrec = inc32(cn); w_lvl = dec8(cl);
    end else if (efound) begin
      do_fn = 1'b1; do_edge = 1'b1;
      if (cl == 8'd1) begin
        w_tot = add64(ct, elapsed); w_nonrec = inc32(cn);
        w_en = inc32(en); w_psub = add64(ps, elapsed); do_psub = 1'b1;
      end
      if (el == 8'd1) w_et = add64(et, elapsed);
      w_el = dec8(el); w_lvl = dec8(cl);
    end
  end

  // Sequence one request through the tables
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0; used <= '0; fvalid <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid && q_ready) begin
          rq <= q_req; f <= req_func;
        end
        // Take the top entry: parent of a call, or the returning function
        S_POP: begin
          is_empty <= (rq.kind == KIND_RET) && (sp == '0);
          if (rq.kind == KIND_CALL) p <= rd_sf;
          else if (sp != '0) begin
            sp <= sp - (SW+1)'(1); f <= rd_sf; t0 <= rd_st;
          end
        end
        // Take the parent of a returning function from the entry below
        S_RDSTK: begin
          si <= '0; efound <= 1'b0;
          has_p <= (sp != '0);
          if (rq.kind == KIND_RET) p <= rd_sf;
        end
        S_SRCH: begin
          if (rq.kind == KIND_RET && sp == '0) has_p <= 1'b0;
          if (has_p && !efound && si < used) begin
            if (state_next == S_SRCHW) si <= si;
          end else if (!efound) e <= used[EW-1:0];
        end
        S_SRCHW: begin
          if (rd_k == kq) begin
            efound <= 1'b1; e <= si[EW-1:0];
          end else si <= si + (EW+1)'(1);
        end
        S_WR: begin
          if (do_push) begin
            stk_f[sp[SW-1:0]] <= f; stk_t[sp[SW-1:0]] <= rq.ts; sp <= sp + (SW+1)'(1);
          end
          if (do_fn) begin
            fc_m[f] <= w_calls; fn_m[f] <= w_nonrec; fl_m[f] <= w_lvl; ft_m[f] <= w_tot;
            if (!c_v) fs_m[f] <= '0;
            fvalid[f] <= 1'b1;
          end
          if (do_psub) begin
            fs_m[p] <= w_psub;
          end
          if (do_edge) begin
            ec_m[e] <= w_ec; en_m[e] <= w_en; el_m[e] <= w_el; et_m[e] <= w_et;
            if (new_edge) begin
              ek_m[e] <= kq; used <= used + (EW+1)'(1);
            end
          end
          out_rsp.status   <= w_status;
          out_rsp.fn_index <= 8'(f);
          out_rsp.edge_calls  <= (w_status == ST_OK && do_edge) ? w_ec : (efound ? r_ec : '0);
          out_rsp.edge_nonrec <= (w_status == ST_OK && do_edge) ? w_en : (efound ? r_en : '0);
          out_rsp.edge_time   <= (w_status == ST_OK && do_edge) ? w_et : (efound ? r_et : '0);
          out_rsp.call_count   <= do_fn ? w_calls : (c_v ? c_calls : '0);
          out_rsp.nonrec_count <= do_fn ? w_nonrec : (c_v ? c_nonrec : '0);
          out_rsp.total_time   <= do_fn ? w_tot : (c_v ? c_tot : '0);
          out_rsp.sub_time     <= (do_psub && p == f) ? w_psub : (c_v ? c_sub : '0);
          out_rsp.stack_depth  <= 8'(do_push ? sp + (SW+1)'(1) : sp);
        end
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/call_graph_profile_accumulator_top.sv */
// ----------------------------------------------------------------------------
// call_graph_profile_accumulator_top
// Call/return event profiler with call stack, function and edge statistics.
// ----------------------------------------------------------------------------
// Input stream s_axis: one call or return event per request. tuser is kind
// (0 call, 1 return); tdata carries func_index and timestamp.
// Output stream m_axis: one result per event with status, the reported
// function's statistics, its parent edge statistics and the stack depth.
// Events pass a two-entry queue into a sequencer that reads the stack, scans
// the edge table one entry at a time through a search and a wait state, reads
// the function table, then writes back. The scan time grows with each edge
// entry scanned. The next event starts the cycle after the result is taken, so
// the sequencer holds one event at a time; the linear edge search over the
// used entries sets the rate.
// Reset empties the stack and the edge table and marks all function entries
// as zero. A stalled receiver holds the result; the queue keeps taking up to
// two more events.
module call_graph_profile_accumulator_top
  import cgpa_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int NUM_FUNCS   = 256,
  parameter int NUM_EDGES   = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // func_index[7:0], timestamp[71:8]
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], fn_index[9:2], call_count[41:10], nonrec_count[73:42],
  // total_time[137:74], sub_time[201:138], edge_calls[233:202],
  // edge_nonrec[265:234], edge_time[329:266], stack_depth[337:330]
  output logic [343:0] m_axis_tdata
);
  req_t in_req, q_req;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign in_req = '{kind: s_axis_tuser, func: s_axis_tdata[7:0], ts: s_axis_tdata[71:8]};

  cgpa_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  cgpa_back #(.STACK_DEPTH(STACK_DEPTH), .NUM_FUNCS(NUM_FUNCS), .NUM_EDGES(NUM_EDGES))
  u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
  );

  assign m_axis_tdata = {6'd0, rsp.stack_depth, rsp.edge_time, rsp.edge_nonrec,
                         rsp.edge_calls, rsp.sub_time, rsp.total_time, rsp.nonrec_count,
                         rsp.call_count, rsp.fn_index, rsp.status};
endmodule

/* rtl/core/cgpa_checker.sv */
// ----------------------------------------------------------------------------
// cgpa_checker
// Port-level checks of the profile accumulator.
// ----------------------------------------------------------------------------
`include "call_graph_profile_accumulator_top_macros.svh"
module cgpa_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [343:0] m_axis_tdata
);
  logic       stall, take;
  logic [1:0] st;
  logic [7:0] depth;

  // Decode the result handshake and fields
  assign stall = m_axis_tvalid && !m_axis_tready;
  assign take  = m_axis_tvalid && m_axis_tready;
  assign st    = m_axis_tdata[1:0];
  assign depth = m_axis_tdata[337:330];

  `CGPA_ASSERT_NEXT(a_hold, clk, rst, stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed")
  `CGPA_ASSERT_IMP(a_status, clk, rst, m_axis_tvalid, st != 2'd3, "bad status code")
  `CGPA_ASSERT_IMP(a_depth, clk, rst, m_axis_tvalid && st == 2'd1, depth == 8'd0, "empty depth")
  `CGPA_ASSERT_NEXT(a_gap, clk, rst, take, !m_axis_tvalid, "results back to back")
endmodule

bind call_graph_profile_accumulator_top cgpa_checker u_cgpa_checker (.*);

/* sim/tb_call_graph_profile_accumulator_top.sv */
// ----------------------------------------------------------------------------
// tb_call_graph_profile_accumulator_top
// Self-checking bench for the call graph profile accumulator: drives call and
// return events with random gaps, predicts each result, checks it in order.
// ----------------------------------------------------------------------------
module tb_call_graph_profile_accumulator_top;
  import cgpa_pkg::*;

  localparam int DEPTH  = 128;
  localparam int NFUNC  = 256;
  localparam int NEDGE  = 1024;

  typedef struct {
    logic        kind;
    logic [7:0]  func;
    logic [63:0] ts;
  } event_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [343:0] m_axis_tdata;

  call_graph_profile_accumulator_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Profiler shadow state
  logic [7:0]  stk_fn [DEPTH];
  logic [63:0] stk_ts [DEPTH];
  int          sp;
  logic [31:0] calls_q [NFUNC];
  logic [31:0] outer_q [NFUNC];
  logic [7:0]  lvl_q   [NFUNC];
  logic [63:0] tot_q   [NFUNC];
  logic [63:0] child_q [NFUNC];
  logic [7:0]  ep [NEDGE];
  logic [7:0]  ec [NEDGE];
  logic [31:0] e_calls [NEDGE];
  logic [31:0] e_outer [NEDGE];
  logic [7:0]  e_lvl   [NEDGE];
  logic [63:0] e_tot   [NEDGE];
  int          edges_used;

  event_t pending_events[$];
  rsp_t   expected_stats[$];
  int     errors = 0;
  int     hold_cycles = 0;
  bit     stim_done = 0;
  logic [63:0] clock_ts = 64'd1000;

  function automatic logic [31:0] sat_inc32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction
  function automatic logic [7:0] sat_inc8(logic [7:0] v);
    return (v == '1) ? v : v + 8'd1;
  endfunction
  function automatic logic [7:0] sat_dec8(logic [7:0] v);
    return (v == '0) ? v : v - 8'd1;
  endfunction
  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic int lookup_edge(logic [7:0] p, logic [7:0] c);
    for (int i = 0; i < edges_used; i++)
      if (ep[i] == p && ec[i] == c) return i;
    return NEDGE;
  endfunction

  function automatic rsp_t make_stats(logic [1:0] st, logic [7:0] f, int e);
    rsp_t r;
    r.status = st;
    r.fn_index = f;
    r.call_count = calls_q[f];
    r.nonrec_count = outer_q[f];
    r.total_time = tot_q[f];
    r.sub_time = child_q[f];
    r.edge_calls = (e < NEDGE) ? e_calls[e] : '0;
    r.edge_nonrec = (e < NEDGE) ? e_outer[e] : '0;
    r.edge_time = (e < NEDGE) ? e_tot[e] : '0;
    r.stack_depth = sp[7:0];
    return r;
  endfunction

  function automatic rsp_t predict_result(event_t ev);
    logic [7:0]  f, p, c;
    logic [63:0] elapsed;
    int          e;
    f = ev.func;
    e = NEDGE;
    if (ev.kind == KIND_CALL) begin
      if (sp > 0) begin
        p = stk_fn[sp-1];
        e = lookup_edge(p, f);
      end
      if (sp >= DEPTH) return make_stats(ST_DROPPED, f, e);
      if (sp > 0) begin
        if (e >= NEDGE) begin
          if (edges_used >= NEDGE) return make_stats(ST_DROPPED, f, e);
          e = edges_used;
          edges_used++;
          ep[e] = p; ec[e] = f;
          e_calls[e] = 0; e_outer[e] = 0; e_lvl[e] = 0; e_tot[e] = 0;
        end
        e_calls[e] = sat_inc32(e_calls[e]);
        e_lvl[e] = sat_inc8(e_lvl[e]);
      end
      stk_fn[sp] = f; stk_ts[sp] = ev.ts; sp++;
      calls_q[f] = sat_inc32(calls_q[f]);
      lvl_q[f] = sat_inc8(lvl_q[f]);
      return make_stats(ST_OK, f, e);
    end
    if (sp == 0) return make_stats(ST_EMPTY, f, NEDGE);
    sp--;
    c = stk_fn[sp];
    elapsed = (ev.ts >= stk_ts[sp]) ? ev.ts - stk_ts[sp] : '0;
    if (sp == 0) begin
      tot_q[c] = sat_add64(tot_q[c], elapsed);
      outer_q[c] = sat_inc32(outer_q[c]);
      lvl_q[c] = sat_dec8(lvl_q[c]);
      return make_stats(ST_OK, c, NEDGE);
    end
    p = stk_fn[sp-1];
    e = lookup_edge(p, c);
    if (e >= NEDGE) return make_stats(ST_OK, c, NEDGE);
    if (lvl_q[c] == 1) begin
      tot_q[c] = sat_add64(tot_q[c], elapsed);
      outer_q[c] = sat_inc32(outer_q[c]);
      e_outer[e] = sat_inc32(e_outer[e]);
      child_q[p] = sat_add64(child_q[p], elapsed);
    end
    if (e_lvl[e] == 1) e_tot[e] = sat_add64(e_tot[e], elapsed);
    e_lvl[e] = sat_dec8(e_lvl[e]);
    lvl_q[c] = sat_dec8(lvl_q[c]);
    return make_stats(ST_OK, c, e);
  endfunction

  task automatic queue_event(logic k, logic [7:0] f, logic [63:0] ts);
    event_t ev;
    ev.kind = k; ev.func = f; ev.ts = ts;
    pending_events.push_back(ev);
  endtask

  // Advancing timestamp with occasional jump backwards
  task automatic queue_step(logic k, logic [7:0] f);
    if ($urandom_range(0, 30) == 0) clock_ts = clock_ts - 64'($urandom_range(0, 500));
    else clock_ts = clock_ts + 64'($urandom_range(0, 200));
    queue_event(k, f, clock_ts);
  endtask

  // Stimulus
  initial begin
    int depth;
    sp = 0; edges_used = 0;
    for (int i = 0; i < NFUNC; i++) begin
      calls_q[i] = 0; outer_q[i] = 0; lvl_q[i] = 0; tot_q[i] = 0; child_q[i] = 0;
    end
    // Directed: empty return, extremes, recursion, backwards time, saturation
    queue_event(KIND_RET, 8'hFF, 64'd5);
    queue_event(KIND_CALL, 8'h00, 64'd0);
    queue_event(KIND_CALL, 8'hFF, 64'd10);
    queue_event(KIND_CALL, 8'hFF, 64'd20);
    queue_event(KIND_RET, 8'h00, 64'd25);
    queue_event(KIND_RET, 8'hAA, 64'd3);
    queue_event(KIND_CALL, 8'h55, '1);
    queue_event(KIND_RET, 8'h55, '1);
    queue_event(KIND_RET, 8'h00, 64'h8000_0000_0000_0000);
    queue_event(KIND_CALL, 8'h01, 64'd0);
    queue_event(KIND_RET, 8'h01, '1);
    queue_event(KIND_CALL, 8'h01, 64'd0);
    queue_event(KIND_RET, 8'h01, '1);
    queue_event(KIND_RET, 8'h01, 64'd0);
    // Fill the stack past full, then unwind
    for (int i = 0; i < DEPTH + 2; i++) queue_step(KIND_CALL, i[7:0] & 8'h0F);
    for (int i = 0; i < DEPTH + 1; i++) queue_step(KIND_RET, 8'h00);
    // Random well-formed call trees with some noise
    depth = 0;
    for (int n = 0; n < 700; n++) begin
      if ($urandom_range(0, 19) == 0)
        queue_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    {$urandom, $urandom});
      else if (depth == 0 || (depth < 20 && $urandom_range(0, 1))) begin
        queue_step(KIND_CALL, $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 15)));
        depth++;
      end else begin
        queue_step(KIND_RET, 8'($urandom_range(0, 255)));
        depth--;
      end
    end
    while (depth > 0) begin
      queue_step(KIND_RET, 8'h00);
      depth--;
    end
    // Many distinct parent-child pairs
    for (int pf = 0; pf < 8; pf++) begin
      queue_step(KIND_CALL, pf[7:0]);
      for (int cf = 0; cf < 8; cf++) begin
        queue_step(KIND_CALL, 8'd100 + cf[7:0]);
        queue_step(KIND_RET, 8'h00);
      end
      queue_step(KIND_RET, 8'h00);
    end
    stim_done = 1;
  end

  // Reset and end of run
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_events.size() == 0 && !s_axis_tvalid);
    wait (expected_stats.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  // Driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_stats.push_back(predict_result(pending_events.pop_front()));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          event_t nx;
          nx = pending_events[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nx.kind;
          s_axis_tdata <= {nx.ts, nx.func};
          if ($urandom_range(0, 3) == 0)
            send_gap <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
                                                     : int'($urandom_range(0, 3));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness with one long hold-off early on
  int accepted_results = 0;
  int ready_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (accepted_results == 30 && hold_cycles < 300) begin
      hold_cycles <= hold_cycles + 1;
      m_axis_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      ready_gap <= int'($urandom_range(0, 2));
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      ready_gap <= int'($urandom_range(10, 40));
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rsp_t got, want;
      got.status       = m_axis_tdata[1:0];
      got.fn_index     = m_axis_tdata[9:2];
      got.call_count   = m_axis_tdata[41:10];
      got.nonrec_count = m_axis_tdata[73:42];
      got.total_time   = m_axis_tdata[137:74];
      got.sub_time     = m_axis_tdata[201:138];
      got.edge_calls   = m_axis_tdata[233:202];
      got.edge_nonrec  = m_axis_tdata[265:234];
      got.edge_time    = m_axis_tdata[329:266];
      got.stack_depth  = m_axis_tdata[337:330];
      accepted_results <= accepted_results + 1;
      if (expected_stats.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", m_axis_tdata[337:0]);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < 10) begin
            $display("mismatch st %0d/%0d fn %0d/%0d calls %0d/%0d outer %0d/%0d",
                     want.status, got.status, want.fn_index, got.fn_index,
                     want.call_count, got.call_count, want.nonrec_count,
                     got.nonrec_count);
            $display("  tot %0d/%0d sub %0d/%0d ec %0d/%0d en %0d/%0d et %0d/%0d sp %0d/%0d",
                     want.total_time, got.total_time, want.sub_time, got.sub_time,
                     want.edge_calls, got.edge_calls, want.edge_nonrec,
                     got.edge_nonrec, want.edge_time, got.edge_time,
                     want.stack_depth, got.stack_depth);
          end
        end
      end
    end
  end
endmodule
